// ===== hdl/double_ended_queue_assert.svh =====
// Assertion macros for the double-ended queue.
// Included by the top level; no other dependencies.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DEQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deque assertion failed");

// Next-cycle implication, disabled while reset is high.
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deque assertion failed");

`endif

// ===== hdl/deq_pkg.sv =====
// Shared constants, types and index helpers for the double-ended queue.
// No dependencies.
package deq_pkg;

   localparam int DEPTH  = 1024;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int WORD_W = 32;
   localparam int FUNC_W = 3;
   localparam int RSP_W  = ((3 * WORD_W + CNT_W + 2 + 7) / 8) * 8;

   localparam logic [WORD_W-1:0] NONE_WORD = '1;

   typedef enum logic [FUNC_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_QUERY      = 3'd4
   } op_type;

   typedef enum logic {
      ST_IDLE,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic exec;     // request accepted: update indices, write slot, start read
      logic finish;   // read data ready: refresh cached ends, load response
   } cmd_type;

   typedef struct packed {
      logic rsp_free; // response register can take a new result this cycle
   } status_type;

   function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
      logic [IDX_W-1:0] r;
      if (i == IDX_W'(DEPTH - 1)) r = '0;
      else r = i + IDX_W'(1);
      return r;
   endfunction

   function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
      logic [IDX_W-1:0] r;
      if (i == '0) r = IDX_W'(DEPTH - 1);
      else r = i - IDX_W'(1);
      return r;
   endfunction

endpackage

// ===== hdl/deq_ctrl.sv =====
// Controller for the double-ended queue: accept, then finish into the response register.
// Depends on deq_pkg.
module deq_ctrl import deq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.exec = 1'b1;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // hold the result until the output register drains
            if (status.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/deq_dpath.sv =====
// Datapath for the double-ended queue: slot memory, indices, cached end words,
// response register. Depends on deq_pkg.
module deq_dpath import deq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [WORD_W-1:0] req_push_value,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata
);

   logic [WORD_W-1:0] slot_mem [DEPTH];
   logic [WORD_W-1:0] rdata_ff;

   logic [IDX_W-1:0]  front_ff, front_in;
   logic [IDX_W-1:0]  back_ff, back_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [WORD_W-1:0] front_word_ff, front_word_in;
   logic [WORD_W-1:0] back_word_ff, back_word_in;
   logic [WORD_W-1:0] popped_ff, popped_in;
   logic              failed_ff, failed_in;
   logic              ref_front_ff, ref_front_in;
   logic              ref_back_ff, ref_back_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              is_full;
   logic              is_zero;
   logic [WORD_W-1:0] front_out;
   logic [WORD_W-1:0] back_out;

   assign is_full = (count_ff == CNT_W'(DEPTH));
   assign is_zero = (count_ff == '0);

   assign status.rsp_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= req_push_value;
      end
      if (rd_en) begin
         rdata_ff <= slot_mem[rd_addr];
      end
   end

   always_comb begin
      front_in      = front_ff;
      back_in       = back_ff;
      count_in      = count_ff;
      front_word_in = front_word_ff;
      back_word_in  = back_word_ff;
      popped_in     = popped_ff;
      failed_in     = failed_ff;
      ref_front_in  = ref_front_ff;
      ref_back_in   = ref_back_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = back_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_next(front_ff);

      if (cmd.exec) begin
         popped_in    = NONE_WORD;
         failed_in    = 1'b0;
         ref_front_in = 1'b0;
         ref_back_in  = 1'b0;
         case (op_type'(req_func))
            OP_PUSH_FRONT: begin
               if (is_full) begin
                  failed_in = 1'b1;
               end else begin
                  front_in      = idx_prev(front_ff);
                  wr_en         = 1'b1;
                  wr_addr       = idx_prev(front_ff);
                  front_word_in = req_push_value;
                  if (is_zero) back_word_in = req_push_value;
                  count_in      = count_ff + CNT_W'(1);
               end
            end
            OP_PUSH_BACK: begin
               if (is_full) begin
                  failed_in = 1'b1;
               end else begin
                  back_in      = idx_next(back_ff);
                  wr_en        = 1'b1;
                  wr_addr      = back_ff;
                  back_word_in = req_push_value;
                  if (is_zero) front_word_in = req_push_value;
                  count_in     = count_ff + CNT_W'(1);
               end
            end
            OP_POP_FRONT: begin
               if (is_zero) begin
                  failed_in = 1'b1;
               end else begin
                  popped_in = front_word_ff;
                  front_in  = idx_next(front_ff);
                  count_in  = count_ff - CNT_W'(1);
                  // fetch the new front word unless the queue drains
                  if (count_ff != CNT_W'(1)) begin
                     rd_en        = 1'b1;
                     rd_addr      = idx_next(front_ff);
                     ref_front_in = 1'b1;
                  end
               end
            end
            OP_POP_BACK: begin
               if (is_zero) begin
                  failed_in = 1'b1;
               end else begin
                  popped_in = back_word_ff;
                  back_in   = idx_prev(back_ff);
                  count_in  = count_ff - CNT_W'(1);
                  // new back word sits two slots below the old back index
                  if (count_ff != CNT_W'(1)) begin
                     rd_en       = 1'b1;
                     rd_addr     = idx_prev(idx_prev(back_ff));
                     ref_back_in = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      front_out = is_zero ? NONE_WORD : (ref_front_ff ? rdata_ff : front_word_ff);
      back_out  = is_zero ? NONE_WORD : (ref_back_ff ? rdata_ff : back_word_ff);

      if (cmd.finish) begin
         if (ref_front_ff) front_word_in = rdata_ff;
         if (ref_back_ff) back_word_in = rdata_ff;
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({back_out, front_out, is_zero, count_ff, failed_ff,
                                popped_ff});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         back_ff      <= '0;
         count_ff     <= '0;
         ref_front_ff <= 1'b0;
         ref_back_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         back_ff      <= back_in;
         count_ff     <= count_in;
         ref_front_ff <= ref_front_in;
         ref_back_ff  <= ref_back_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_word_ff <= front_word_in;
      back_word_ff  <= back_word_in;
      popped_ff     <= popped_in;
      failed_ff     <= failed_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

// ===== hdl/double_ended_queue.sv =====
// Double-ended queue, 1024 words deep, circular slot memory with cached end words.
// The response is loaded into the output register in the finish state, after the registered
// slot memory read and once the output register is free. A new request is taken only after
// the previous one has finished, which waits for the read that refreshes the front or back word after a pop.
// A new request is taken while the previous response still waits in the output register.
// Reset (synchronous, active high) empties the queue at once; no clearing pass.
`include "double_ended_queue_assert.svh"
module double_ended_queue import deq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [WORD_W-1:0] req_tdata,  // push_value
   input  logic [FUNC_W-1:0] req_tuser,  // func
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // popped_value, op_failed, entry_count, is_empty, front_value, back_value, zero pad
   output logic [RSP_W-1:0]  rsp_tdata
);

   cmd_type    cmd;
   status_type status;

   deq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   deq_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_func       (req_tuser),
      .req_push_value (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata)
   );

   logic [CNT_W-1:0]  mon_count;
   logic              mon_empty;
   logic [WORD_W-1:0] mon_front;
   logic [WORD_W-1:0] mon_back;
   logic              mon_ends_none;

   assign mon_count     = rsp_tdata[WORD_W + 1 +: CNT_W];
   assign mon_empty     = rsp_tdata[WORD_W + 1 + CNT_W];
   assign mon_front     = rsp_tdata[WORD_W + CNT_W + 2 +: WORD_W];
   assign mon_back      = rsp_tdata[2 * WORD_W + CNT_W + 2 +: WORD_W];
   assign mon_ends_none = (mon_front == NONE_WORD) && (mon_back == NONE_WORD);

   `DEQ_ASSERT_IMPL(a_count_range, clock, reset, rsp_tvalid, mon_count <= CNT_W'(DEPTH))
   `DEQ_ASSERT_IMPL(a_empty_flag, clock, reset, rsp_tvalid, mon_empty == (mon_count == '0))
   `DEQ_ASSERT_IMPL(a_empty_words, clock, reset, rsp_tvalid && mon_empty, mon_ends_none)
   `DEQ_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule
